/* rtl/rr_pkg.sv */
// ----------------------------------------------------------------------------
// rr_pkg
// Shared types and constants for the rank remap block.
// ----------------------------------------------------------------------------
package rr_pkg;

   localparam int RR_SET_DEPTH = 64;   // default store depth
   localparam int RR_VALUE_W   = 32;   // element / result width

   typedef enum logic [2:0] {
      RR_IDLE,
      RR_FETCH,
      RR_REF,
      RR_SCAN,
      RR_EMIT
   } rr_state_type;

   // controls for the shared compare unit
   typedef struct packed {
      logic load_ref;   // capture read data as the reference element
      logic clear;      // zero the rank accumulator
      logic step;       // compare read data against reference, count if smaller
   } rr_cmp_ctl_type;

endpackage

/* rtl/rank_remap_top.sv */
// ----------------------------------------------------------------------------
// rank_remap_top
// Rank transform of a set of signed 32-bit values: each element is replaced
// by the count of set elements strictly smaller than it, or kept if alone.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  req     | in  | req_valid / req_stall | req_sample_value, req_final_item
//  rsp     | out | rsp_valid / rsp_stall | rsp_remapped_value, rsp_run_end
//
//  Load: one beat per cycle into the value RAM until the final beat.
//  Rank: per element a fetch, a reference capture, n compare steps through
//    the single RAM read port and the shared comparator, and an emit, for
//    a set of n elements; req_stall is high meanwhile.
//  Reset is synchronous: clears sequencer, element count and the output valid.
//  rsp_stall only holds the emit step; the output register keeps the beat.
//
module rank_remap_top
   import rr_pkg::*;
#(
   parameter int SET_DEPTH = RR_SET_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [RR_VALUE_W-1:0] req_sample_value,
   input  logic                         req_final_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [RR_VALUE_W-1:0] rsp_remapped_value,
   output logic                         rsp_run_end
);

   localparam int ADDR_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CNT_W  = $clog2(SET_DEPTH + 1);

   rr_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;   // elements held; set size while ranking
   logic [CNT_W-1:0] k_ff, k_in;           // element being ranked
   logic [CNT_W-1:0] j_ff, j_in;           // next scan read address
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [RR_VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_end_ff, rsp_end_in;

   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [ADDR_W-1:0]            ram_rd_addr;
   logic signed [RR_VALUE_W-1:0] ram_rd_data;

   rr_cmp_ctl_type               cmp_ctl;
   logic signed [RR_VALUE_W-1:0] ref_value;
   logic [ADDR_W-1:0]            rank;

   logic rsp_take;
   logic last_elem;

   rr_ram #(
      .Width (RR_VALUE_W),
      .Depth (SET_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_sample_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rr_cmp_unit #(
      .RankW (ADDR_W)
   ) u_cmp (
      .clock     (clock),
      .ctl       (cmp_ctl),
      .cand      (ram_rd_data),
      .ref_value (ref_value),
      .rank      (rank)
   );

   assign req_stall = (state_ff != RR_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign last_elem = ((k_ff + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = k_ff[ADDR_W-1:0];
      cmp_ctl      = '0;

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         RR_IDLE: begin
            if (req_valid) begin
               // beyond the store depth values are dropped
               if (count_ff < CNT_W'(SET_DEPTH)) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               if (req_final_item) begin
                  k_in     = '0;
                  state_in = RR_FETCH;
               end
            end
         end
         RR_FETCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = k_ff[ADDR_W-1:0];
            state_in    = RR_REF;
         end
         RR_REF: begin
            cmp_ctl.load_ref = 1'b1;
            cmp_ctl.clear    = 1'b1;
            ram_rd_en        = 1'b1;
            ram_rd_addr      = '0;
            j_in             = CNT_W'(1);
            state_in         = RR_SCAN;
         end
         RR_SCAN: begin
            cmp_ctl.step = 1'b1;
            if (j_ff == count_ff) begin
               state_in = RR_EMIT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = j_ff[ADDR_W-1:0];
               j_in        = j_ff + CNT_W'(1);
            end
         end
         RR_EMIT: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = last_elem;
               // single-element set passes the value through
               if (count_ff == CNT_W'(1)) begin
                  rsp_value_in = ref_value;
               end else begin
                  rsp_value_in = $signed(RR_VALUE_W'(rank));
               end
               if (last_elem) begin
                  count_in = '0;
                  state_in = RR_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = RR_FETCH;
               end
            end
         end
         default: begin
            state_in = RR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RR_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_remapped_value = rsp_value_ff;
   assign rsp_run_end        = rsp_end_ff;

endmodule

/* rtl/rr_ram.sv */
// ----------------------------------------------------------------------------
// rr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rr_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                        rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rr_cmp_unit.sv */
// ----------------------------------------------------------------------------
// rr_cmp_unit
// Shared signed comparator with rank accumulator; one compare per cycle.
// ----------------------------------------------------------------------------
module rr_cmp_unit
   import rr_pkg::*;
#(
   parameter int RankW = 6
) (
   input  logic                         clock,
   input  rr_cmp_ctl_type               ctl,
   input  logic signed [RR_VALUE_W-1:0] cand,
   output logic signed [RR_VALUE_W-1:0] ref_value,
   output logic [RankW-1:0]             rank
);

   logic signed [RR_VALUE_W-1:0] ref_ff;
   logic signed [RR_VALUE_W-1:0] ref_in;
   logic [RankW-1:0]             rank_ff;
   logic [RankW-1:0]             rank_in;

   always_comb begin
      ref_in  = ref_ff;
      rank_in = rank_ff;
      if (ctl.load_ref) begin
         ref_in = cand;
      end
      if (ctl.clear) begin
         rank_in = '0;
      end else if (ctl.step && (cand < ref_ff)) begin
         rank_in = rank_ff + RankW'(1);
      end
   end

   always_ff @(posedge clock) begin
      ref_ff  <= ref_in;
      rank_ff <= rank_in;
   end

   assign ref_value = ref_ff;
   assign rank      = rank_ff;

endmodule

/* rtl/rr_chk.sv */
// ----------------------------------------------------------------------------
// rr_chk
// Port-level checks for rank_remap_top, attached by bind.
// ----------------------------------------------------------------------------
module rr_chk
   import rr_pkg::*;
#(
   parameter int SET_DEPTH = RR_SET_DEPTH
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic signed [RR_VALUE_W-1:0] req_sample_value,
   input logic                         req_final_item,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [RR_VALUE_W-1:0] rsp_remapped_value,
   input logic                         rsp_run_end
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_remapped_value)
         && $stable(rsp_run_end))
      else $error("rsp beat changed while stalled");

   // a final beat starts ranking, input closes next cycle
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_final_item |=> req_stall)
      else $error("input open right after final beat");

   // stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_sample_value)
         && $stable(req_final_item))
      else $error("req beat changed while stalled");

   // results before the run end are ranks of a multi-element set
   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> ($unsigned(rsp_remapped_value) < SET_DEPTH))
      else $error("rank out of range");

   // nothing shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind rank_remap_top rr_chk #(
   .SET_DEPTH (SET_DEPTH)
) u_rr_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_sample_value   (req_sample_value),
   .req_final_item     (req_final_item),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_remapped_value (rsp_remapped_value),
   .rsp_run_end        (rsp_run_end)
);
